/* design/mte_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mte_pkg: shared types and constants for the markup word extractor
// Byte codes, the front-to-back command, word buffer write port, result item
// and the back-end state type.
// ----------------------------------------------------------------------------
package mte_pkg;

	// default word length limit and counter width covering its full range
	localparam int WORD_LIMIT_DEF = 64;
	localparam int CNT_W          = 7;

	// byte codes
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CASE_OFS = 8'h20;

	// flush command handed from the front end to the back end
	typedef struct packed {
		logic             has_word;  // a trimmed, non-empty word is in the buffer
		logic             space;     // emit a separating space first
		logic             done;      // this command closes the text
		logic [CNT_W-1:0] first;     // index of first alphanumeric byte
		logic [CNT_W-1:0] last;      // one past last alphanumeric byte
	} mte_cmd_t;

	// word buffer write port
	typedef struct packed {
		logic             en;
		logic [CNT_W-1:0] addr;
		logic [7:0]       data;
	} mte_wr_t;

	// one result item
	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       run_last;
		logic       text_done;
	} mte_res_t;

	// back-end sequencer states
	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MARK,
		BK_SPACE,
		BK_READ,
		BK_LOAD
	} mte_bk_state_t;

	function automatic logic is_upper(input logic [7:0] c);
		return (c >= 8'h41) && (c <= 8'h5A);
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return ((c >= 8'h30) && (c <= 8'h39)) || is_upper(c) ||
			((c >= 8'h61) && (c <= 8'h7A));
	endfunction

endpackage
`default_nettype wire

/* design/mte_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mte_front: input classifier
// Tracks tag nesting, word length and the alphanumeric bounds of the pending
// word, writes word bytes to the buffer and issues flush commands.
// ----------------------------------------------------------------------------
module mte_front import mte_pkg::*; #(
	parameter int WORD_LIMIT = WORD_LIMIT_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] text_byte,
	input  wire logic       end_of_text,
	output mte_wr_t         wr,
	output logic            cmd_push,
	output mte_cmd_t        cmd,
	input  wire logic       cmd_full,
	input  wire logic       word_done,
	output logic            busy
);

	localparam logic [CNT_W-1:0] LIMIT     = CNT_W'(WORD_LIMIT);
	localparam logic [CNT_W-1:0] STORE_MAX = CNT_W'(WORD_LIMIT - 1);

	logic             inside_q, seen_q, any_q, busy_q;
	logic [CNT_W-1:0] cnt_q, first_q, last_q;

	logic             acc, is_sep, is_word, store, alnum, flush, word_ok;
	logic             nx_inside, nx_seen;
	logic [CNT_W-1:0] nx_cnt, nx_first, nx_last;

	// input handshake: hold off while the back end drains the buffer or the command queue is full
	assign in_ready = !busy_q && !cmd_full;
	assign acc      = in_valid && in_ready;
	assign busy     = busy_q;

	// byte classification and next word bounds
	always_comb begin
		is_sep    = !inside_q && ((text_byte == CH_LT) || (text_byte == CH_SP));
		is_word   = !inside_q && !is_sep;
		nx_inside = inside_q ? (text_byte != CH_GT) : (text_byte == CH_LT);
		store     = is_word && (cnt_q < STORE_MAX);
		alnum     = is_alnum(text_byte);
		nx_seen   = seen_q || (store && alnum);
		nx_first  = (store && alnum && !seen_q) ? cnt_q : first_q;
		nx_last   = (store && alnum) ? (cnt_q + CNT_W'(1)) : last_q;
		nx_cnt    = (is_word && (cnt_q < LIMIT)) ? (cnt_q + CNT_W'(1)) : cnt_q;
		flush     = is_sep || end_of_text;
		word_ok   = flush && nx_seen && (nx_cnt < LIMIT);
	end

	// command and buffer write
	always_comb begin
		cmd_push     = acc && (word_ok || end_of_text);
		cmd.has_word = word_ok;
		cmd.space    = any_q;
		cmd.done     = end_of_text;
		cmd.first    = nx_first;
		cmd.last     = nx_last;
		wr.en        = acc && store;
		wr.addr      = cnt_q;
		wr.data      = text_byte;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			seen_q   <= 1'b0;
			any_q    <= 1'b0;
			cnt_q    <= '0;
			busy_q   <= 1'b0;
		end else begin
			if (acc) begin
				inside_q <= end_of_text ? 1'b0 : nx_inside;
				seen_q   <= flush ? 1'b0 : nx_seen;
				cnt_q    <= flush ? '0 : nx_cnt;
				any_q    <= end_of_text ? 1'b0 : (any_q || word_ok);
			end
			if (cmd_push && word_ok)
				busy_q <= 1'b1;
			else if (word_done)
				busy_q <= 1'b0;
		end
	end

	// word bounds, only meaningful while seen_q is set
	always_ff @(posedge clk) begin
		if (acc) begin
			first_q <= nx_first;
			last_q  <= nx_last;
		end
	end

endmodule
`default_nettype wire

/* design/mte_cmd_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mte_cmd_fifo: two-entry command queue
// Decouples the classifier from the emitter.
// ----------------------------------------------------------------------------
module mte_cmd_fifo import mte_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire mte_cmd_t  din,
	output logic           full,
	input  wire logic      pop,
	output mte_cmd_t       dout,
	output logic           empty
);

	mte_cmd_t   mem_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign dout  = mem_q[rptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push)
				wptr_q <= !wptr_q;
			if (pop)
				rptr_q <= !rptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= din;
	end

endmodule
`default_nettype wire

/* design/mte_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mte_back: word emitter
// Holds the word buffer, walks a flushed word from its first to its last
// alphanumeric byte and drives the registered result stream.
// ----------------------------------------------------------------------------
module mte_back import mte_pkg::*; #(
	parameter int WORD_LIMIT = WORD_LIMIT_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire mte_wr_t   wr,
	input  wire mte_cmd_t  cmd,
	input  wire logic      cmd_empty,
	output logic           cmd_pop,
	output logic           word_done,
	output logic           out_valid,
	input  wire logic      out_ready,
	output mte_res_t       res
);

	localparam int DEPTH  = WORD_LIMIT - 1;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [7:0]       buf_mem [DEPTH];
	logic [7:0]       rd_data_q;

	mte_bk_state_t    st_q, st_nx;
	logic [CNT_W-1:0] idx_q, last_q;
	logic             done_q, first_flag_q;
	logic             out_valid_q;
	mte_res_t         res_q;

	logic             out_free, at_end, ld, adv;
	mte_res_t         ld_res;
	logic [7:0]       cur_byte;

	assign out_free  = !out_valid_q || out_ready;
	assign at_end    = ((idx_q + CNT_W'(1)) == last_q);
	assign out_valid = out_valid_q;
	assign res       = res_q;

	// word buffer: one write, one registered read
	always_ff @(posedge clk) begin
		if (wr.en)
			buf_mem[wr.addr[ADDR_W-1:0]] <= wr.data;
		rd_data_q <= buf_mem[idx_q[ADDR_W-1:0]];
	end

	// next state
	always_comb begin
		st_nx = st_q;
		unique case (st_q)
			BK_IDLE: begin
				if (!cmd_empty)
					st_nx = !cmd.has_word ? BK_MARK : (cmd.space ? BK_SPACE : BK_READ);
			end
			BK_MARK: begin
				if (out_free)
					st_nx = BK_IDLE;
			end
			BK_SPACE: begin
				if (out_free)
					st_nx = BK_READ;
			end
			BK_READ: st_nx = BK_LOAD;
			BK_LOAD: begin
				if (out_free)
					st_nx = at_end ? BK_IDLE : BK_READ;
			end
			default: st_nx = BK_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		cur_byte  = (first_flag_q && is_upper(rd_data_q)) ? (rd_data_q + CASE_OFS)
			: rd_data_q;
		cmd_pop   = 1'b0;
		ld        = 1'b0;
		adv       = 1'b0;
		word_done = 1'b0;
		ld_res    = '{out_byte: CH_NUL, byte_valid: 1'b0, run_last: 1'b1, text_done: 1'b1};
		unique case (st_q)
			BK_IDLE:  cmd_pop = !cmd_empty;
			BK_MARK:  ld = out_free;
			BK_SPACE: begin
				ld     = out_free;
				ld_res = '{out_byte: CH_SP, byte_valid: 1'b1, run_last: 1'b0, text_done: 1'b0};
			end
			BK_READ:  ld = 1'b0;
			BK_LOAD: begin
				ld        = out_free;
				adv       = out_free;
				word_done = out_free && at_end;
				ld_res    = '{out_byte: cur_byte, byte_valid: 1'b1, run_last: at_end,
					text_done: at_end && done_q};
			end
			default: ld = 1'b0;
		endcase
	end

	// sequencer and output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_nx;
			if (ld)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// word walk and result payload
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			idx_q        <= cmd.first;
			last_q       <= cmd.last;
			done_q       <= cmd.done;
			first_flag_q <= 1'b1;
		end else if (adv) begin
			idx_q        <= idx_q + CNT_W'(1);
			first_flag_q <= 1'b0;
		end
		if (ld)
			res_q <= ld_res;
	end

endmodule
`default_nettype wire

/* design/markup_tag_strip_word_extract.sv */
`timescale 1ns / 1ps
`default_nettype none
// Flow: a byte that only extends a word or sits in a tag is simply accepted.
// A word flush passes through the command queue and the optional separating space state,
// then a buffer read state and an output register load state per emitted byte, as the
// buffer read is registered. Input is held off while a flushed word drains.
// An end marker goes through the command queue and the marker state to the output register.
// Reset: arst_n clears tag, word and sequencer state; no clearing pass.
// ----------------------------------------------------------------------------
// markup_tag_strip_word_extract: markup tag stripper and word extractor
// Drops tags, splits words on space and '<', trims and emits words.
// ----------------------------------------------------------------------------
module markup_tag_strip_word_extract import mte_pkg::*; #(
	parameter int WORD_LIMIT = WORD_LIMIT_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // [7:0] text_byte
	input  wire logic       s_axis_tlast,   // end_of_text
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
	output logic [1:0]      m_axis_tuser,   // [0] byte_valid, [1] text_done
	output logic            m_axis_tlast    // run_last
);

	mte_wr_t  wr;
	mte_cmd_t cmd_in, cmd_out;
	mte_res_t res;
	logic     cmd_push, cmd_full, cmd_pop, cmd_empty, word_done, busy;

	mte_front #(.WORD_LIMIT(WORD_LIMIT)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.text_byte  (s_axis_tdata),
		.end_of_text(s_axis_tlast),
		.wr         (wr),
		.cmd_push   (cmd_push),
		.cmd        (cmd_in),
		.cmd_full   (cmd_full),
		.word_done  (word_done),
		.busy       (busy)
	);

	mte_cmd_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cmd_push),
		.din   (cmd_in),
		.full  (cmd_full),
		.pop   (cmd_pop),
		.dout  (cmd_out),
		.empty (cmd_empty)
	);

	mte_back #(.WORD_LIMIT(WORD_LIMIT)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.cmd      (cmd_out),
		.cmd_empty(cmd_empty),
		.cmd_pop  (cmd_pop),
		.word_done(word_done),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.res      (res)
	);

	assign m_axis_tdata = res.out_byte;
	assign m_axis_tuser = {res.text_done, res.byte_valid};
	assign m_axis_tlast = res.run_last;

	// checks
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !cmd_full) else $error("command queue overflow");

	a_no_write_while_drain: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !wr.en) else $error("buffer written while a word drains");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
		else $error("text end not on last transfer of its run");

	a_marker_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tuser[1] && m_axis_tlast)
		else $error("bare marker without end flags");

endmodule
`default_nettype wire

/* sim/mte_plain_text_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mte_plain_text_check: output checker for the markup word extractor
// Watches both stream channels. Every accepted text byte runs through a local
// model of the tag stripper and word trimmer. The plain-text bytes it predicts
// are queued, and each output transfer is compared with the oldest of them.
// ----------------------------------------------------------------------------
module mte_plain_text_check import mte_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,    // [7:0] text_byte
	input  logic       s_tlast,    // end_of_text
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,    // [7:0] out_byte
	input  logic [1:0] m_tuser,    // [0] byte_valid, [1] text_done
	input  logic       m_tlast,    // run_last
	output int         errors,
	output int         pending,
	output int         checked,
	output int         texts
);

	localparam int WLIM       = WORD_LIMIT_DEF;
	localparam int MAX_REPORT = 10;

	// local copy of the extractor state
	logic       in_tag;
	logic [7:0] word_buf [0:WLIM-2];
	int         word_len;
	logic       emitted_any;

	// results of the current text byte, and all results still owed by the block
	mte_res_t step_res[$];
	mte_res_t plain_q[$];

	int mism_cnt;
	int good_cnt;
	int text_cnt;

	function automatic logic word_char(input logic [7:0] c);
		logic digit, upper, lower;
		digit = (c >= 8'h30) && (c <= 8'h39);
		upper = (c >= 8'h41) && (c <= 8'h5A);
		lower = (c >= 8'h61) && (c <= 8'h7A);
		return digit | upper | lower;
	endfunction

	task automatic push_byte(input logic [7:0] b);
		mte_res_t r;
		r = '0;
		r.out_byte   = b;
		r.byte_valid = 1'b1;
		step_res.push_back(r);
	endtask

	// close the pending word: drop if too long, trim, lowercase first letter
	task automatic flush_pending();
		int         lo, hi;
		logic [7:0] c;
		lo = 0;
		hi = word_len;
		word_len = 0;
		if (hi == 0 || hi >= WLIM)
			return;
		while (lo < hi && !word_char(word_buf[lo]))
			lo++;
		while (hi > lo && !word_char(word_buf[hi-1]))
			hi--;
		if (hi == lo)
			return;
		if (emitted_any)
			push_byte(CH_SP);
		for (int i = lo; i < hi; i++) begin
			c = word_buf[i];
			if (i == lo && c >= 8'h41 && c <= 8'h5A)
				c = c + CASE_OFS;
			push_byte(c);
		end
		emitted_any = 1'b1;
	endtask

	// expected results for one accepted text byte
	task automatic predict_text_byte(input logic [7:0] b, input logic eot);
		mte_res_t r;
		int       n;
		step_res.delete();
		if (in_tag) begin
			if (b == CH_GT)
				in_tag = 1'b0;
		end else if (b == CH_LT) begin
			flush_pending();
			in_tag = 1'b1;
		end else if (b == CH_SP) begin
			flush_pending();
		end else begin
			if (word_len < WLIM - 1)
				word_buf[word_len] = b;
			if (word_len < WLIM)
				word_len++;
		end
		// end of text: flush, reset text state, bare marker if nothing came out
		if (eot) begin
			flush_pending();
			in_tag      = 1'b0;
			word_len    = 0;
			emitted_any = 1'b0;
			if (step_res.size() == 0) begin
				r = '0;
				step_res.push_back(r);
			end
			n = step_res.size();
			r = step_res[n-1];
			r.text_done = 1'b1;
			step_res[n-1] = r;
		end
		n = step_res.size();
		if (n > 0) begin
			r = step_res[n-1];
			r.run_last = 1'b1;
			step_res[n-1] = r;
		end
		for (int i = 0; i < n; i++)
			plain_q.push_back(step_res[i]);
	endtask

	// predict on input transfers, compare on output transfers
	always @(posedge clk or negedge arst_n) begin
		mte_res_t got, want;
		if (!arst_n) begin
			in_tag      = 1'b0;
			word_len    = 0;
			emitted_any = 1'b0;
			plain_q.delete();
			mism_cnt = 0;
			good_cnt = 0;
			text_cnt = 0;
		end else begin
			if (s_tvalid && s_tready)
				predict_text_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				got.out_byte   = m_tdata;
				got.byte_valid = m_tuser[0];
				got.text_done  = m_tuser[1];
				got.run_last   = m_tlast;
				if (plain_q.size() == 0) begin
					mism_cnt++;
					if (mism_cnt <= MAX_REPORT)
						$display("%0t unexpected output: byte %h valid %b last %b done %b",
							$realtime, got.out_byte, got.byte_valid, got.run_last,
							got.text_done);
				end else begin
					want = plain_q.pop_front();
					if (got !== want) begin
						mism_cnt++;
						if (mism_cnt <= MAX_REPORT)
							$display({"%0t mismatch: expected byte %h valid %b last %b done %b,",
								" got byte %h valid %b last %b done %b"}, $realtime,
								want.out_byte, want.byte_valid, want.run_last,
								want.text_done, got.out_byte, got.byte_valid,
								got.run_last, got.text_done);
					end else begin
						good_cnt++;
					end
					if (want.text_done)
						text_cnt++;
				end
			end
		end
		errors  <= mism_cnt;
		pending <= plain_q.size();
		checked <= good_cnt;
		texts   <= text_cnt;
	end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: top-level testbench for markup_tag_strip_word_extract
// Feeds directed and random markup texts through the extractor under three
// idle patterns and one long output hold-off. Checking is done by
// mte_plain_text_check; this module drives stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb import mte_pkg::*;;

	localparam int RANDOM_ITEMS = 260;
	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int DRAIN_CYCLES = 16;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = '0;    // [7:0] text_byte
	logic       s_axis_tlast = 1'b0;  // end_of_text
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;         // [7:0] out_byte
	logic [1:0] m_axis_tuser;         // [0] byte_valid, [1] text_done
	logic       m_axis_tlast;         // run_last

	int errors, pending, checked, texts;

	// idle rates in percent, changed per phase
	int   src_idle = 26;
	int   snk_idle = 58;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;

	int unsigned cycles = 0;

	// text bytes queued for sending
	logic [7:0] text_bytes[$];
	logic       text_ends[$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	markup_tag_strip_word_extract dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	mte_plain_text_check chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.s_tdata  (s_axis_tdata),
		.s_tlast  (s_axis_tlast),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.m_tdata  (m_axis_tdata),
		.m_tuser  (m_axis_tuser),
		.m_tlast  (m_axis_tlast),
		.errors   (errors),
		.pending  (pending),
		.checked  (checked),
		.texts    (texts)
	);

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// output side: random ready, one long hold-off when requested
	always begin
		@(posedge clk);
		if (hold_req && !hold_done) begin
			m_axis_tready <= 1'b0;
			hold_done = 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
		end else begin
			m_axis_tready <= ($urandom_range(99) >= snk_idle);
		end
	end

	// ---- text generation ----

	task automatic put(input logic [7:0] b);
		text_bytes.push_back(b);
		text_ends.push_back(1'b0);
	endtask

	task automatic put_str(input string s);
		for (int i = 0; i < s.len(); i++)
			put(s[i]);
	endtask

	task automatic close_text();
		text_ends[text_ends.size()-1] = 1'b1;
	endtask

	function automatic logic [7:0] rand_alnum();
		logic [7:0] c;
		case ($urandom_range(2))
			0:       c = 8'h30 + 8'($urandom_range(9));
			1:       c = 8'h41 + 8'($urandom_range(25));
			default: c = 8'h61 + 8'($urandom_range(25));
		endcase
		return c;
	endfunction

	function automatic logic [7:0] rand_punct();
		string p;
		p = "!,.;:?()-_#&'";
		return p[$urandom_range(p.len()-1)];
	endfunction

	// word bytes: mostly letters and digits, some punctuation, stray '>' and
	// arbitrary bytes; long words start and end on a letter or digit so they survive trim
	task automatic gen_word(input int n);
		logic [7:0] b;
		int         roll;
		for (int i = 0; i < n; i++) begin
			roll = $urandom_range(99);
			if (roll < 60)
				b = rand_alnum();
			else if (roll < 80)
				b = rand_punct();
			else if (roll < 86)
				b = CH_GT;
			else begin
				b = 8'($urandom_range(255));
				if (b == CH_SP || b == CH_LT)
					b = 8'hFF;
			end
			if (n >= 60 && (i == 0 || i == n - 1))
				b = rand_alnum();
			put(b);
		end
	endtask

	task automatic gen_tag();
		logic [7:0] b;
		put(CH_LT);
		repeat ($urandom_range(6)) begin
			b = 8'($urandom_range(255));
			if (b == CH_GT)
				b = CH_LT;
			put(b);
		end
		put(CH_GT);
	endtask

	task automatic gen_text();
		int ntok, roll;
		ntok = $urandom_range(1, 8);
		for (int t = 0; t < ntok; t++) begin
			roll = $urandom_range(99);
			if (roll < 55) begin
				if ($urandom_range(39) == 0)
					gen_word($urandom_range(62, 70));
				else
					gen_word($urandom_range(1, 9));
				if ($urandom_range(3) != 0)
					put(CH_SP);
			end else if (roll < 75) begin
				gen_tag();
			end else if (roll < 90) begin
				repeat ($urandom_range(1, 3)) put(CH_SP);
			end else begin
				put(8'($urandom_range(255)));
			end
		end
		// how the text ends: open tag, on a space, or inside a word
		roll = $urandom_range(99);
		if (roll < 10) begin
			put(CH_LT);
			repeat ($urandom_range(2)) put(rand_alnum());
		end else if (roll < 20) begin
			put(CH_SP);
		end else begin
			gen_word($urandom_range(1, 6));
		end
		close_text();
	endtask

	// ---- input side ----

	task automatic send_item(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < src_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= last;
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	initial begin
		int n_directed, total, third;

		// directed texts
		put_str("<a>Hi x!");            // tag, uppercase first letter, trailing trim
		close_text();
		put(CH_SP);                     // text of one space: bare end marker
		close_text();
		put_str("Zq<a");                // word cut by '<', text ends inside a tag
		close_text();
		put(8'hFF);                     // high bytes and NUL trimmed, empty words,
		put_str("9");                   // stray '>' kept as a word byte
		put(CH_NUL);
		put_str("  .. >a");
		put(8'h80);
		close_text();
		n_directed = text_bytes.size();

		// longest kept word, first dropped word, then random texts
		gen_word(2);
		put(CH_SP);
		gen_word(WORD_LIMIT_DEF - 1);
		put(CH_SP);
		gen_word(WORD_LIMIT_DEF);
		close_text();
		while (text_bytes.size() < n_directed + RANDOM_ITEMS)
			gen_text();

		total = text_bytes.size();
		third = total / 3;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < total; i++) begin
			if (i == third) begin
				src_idle = 58;
				snk_idle = 26;
			end
			if (i == 2 * third) begin
				src_idle = 0;
				snk_idle = 0;
				hold_req = 1'b1;
			end
			send_item(text_bytes[i], text_ends[i]);
		end
		s_axis_tvalid <= 1'b0;

		// drain
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d text bytes (%0d directed) in %0d texts, %0d output transfers matched",
			total, n_directed, texts, checked);
		$display("idle mixes 26/58, 58/26 and none, plus a %0d-cycle output hold-off",
			HOLD_CYCLES);
		if (errors == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
